/* design/mwo_pkg.sv */
// Shared types, constants and the sine table generator for the
// multi-waveform oscillator. No dependencies.
`default_nettype none

package mwo_pkg;

    localparam int FREQ_W      = 32;
    localparam int RATE_W      = 18;
    localparam int SHAPE_W     = 3;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 32;
    // Width of the divider words: the output rate shifted left by 16 needs 34 bits.
    localparam int DIV_W       = RATE_W + 16;
    localparam int DIV_STEP_W  = $clog2(DIV_W + 1);
    localparam int CFG_INDEX_W = 4;

    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int PHASE_BITS_DEF      = 16;

    localparam logic [FREQ_W-1:0] MIN_FREQ_RAW = 32'd656;
    localparam logic [RATE_W-1:0] RATE_RESET   = 18'd44100;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [SHAPE_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SAW      = 3'd3,
        WAVE_RSAW     = 3'd4
    } wave_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE  = 4'd1;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_cmd_t;

    // Quarter-wave sine entry in Q1.15, built from a Taylor series in Q2.30
    // with every product truncated. Evaluated at elaboration only.
    function automatic logic [SAMPLE_W-1:0] sine_q15(input int idx, input int table_bits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint prod;
        longint v;
        x    = (HALF_PI_Q30 * longint'(idx)) >>> (table_bits - 2);
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            prod = (term * x2) >>> 30;
            unique case (k)
                1: term = prod / 6;
                2: term = prod / 20;
                3: term = prod / 42;
                4: term = prod / 72;
                5: term = prod / 110;
                6: term = prod / 156;
                default: term = prod / 210;
            endcase
            if ((k & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/mwo_divider.sv */
// Shared restoring divider, one quotient bit per clock.
// Depends on mwo_pkg for the word widths and the command struct.
`default_nettype none

module mwo_divider
    import mwo_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire div_cmd_t         cmd,
    input  wire logic [DIV_W-1:0] rem_init,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient,
    output logic      [DIV_W-1:0] remainder
);

    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dvd_reg;
    logic [DIV_W-1:0]      dsr_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIV_W:0]   partial;
    logic [DIV_W+1:0] diff;
    logic             fits;

    // The remainder stays below the divisor, so the shifted partial fits
    // in one more bit and one subtraction decides each quotient bit.
    assign partial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, dsr_reg};
    assign fits    = ~diff[DIV_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                rem_reg  <= rem_init;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                quo_reg  <= '0;
                cnt_reg  <= cmd.steps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
                dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - DIV_STEP_W'(1);
                if (cnt_reg == DIV_STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* design/mwo_shaper.sv */
// Maps phase, counter and period to one Q1.15 sample of the chosen wave.
// Depends on mwo_pkg for widths, wave codes and the sine table function.
`default_nettype none

module mwo_shaper
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
    input  wire logic [SHAPE_W-1:0]    wave_shape,
    input  wire logic [PHASE_BITS-1:0] phase,
    input  wire logic [DIV_W-1:0]      pos_in_period,
    input  wire logic [DIV_W-1:0]      period,
    output logic      [SAMPLE_W-1:0]   sample
);

    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int TAB_IDX_W   = SINE_TABLE_BITS - 1;

    logic [SAMPLE_W-1:0] quarter_tab [0:QUARTER_LEN];

    for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_tab
        assign quarter_tab[g] = sine_q15(g, SINE_TABLE_BITS);
    end

    logic [SINE_TABLE_BITS-1:0] sine_idx;

    if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_idx_trunc
        assign sine_idx = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    end else begin : g_idx_widen
        assign sine_idx = {phase, {(SINE_TABLE_BITS - PHASE_BITS){1'b0}}};
    end

    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-3:0] qpos;
    logic [TAB_IDX_W-1:0]       tab_idx;
    logic [SAMPLE_W-1:0]        tab_val;

    assign quad    = sine_idx[SINE_TABLE_BITS-1 -: 2];
    assign qpos    = sine_idx[SINE_TABLE_BITS-3:0];
    assign tab_idx = quad[0] ? (TAB_IDX_W'(QUARTER_LEN) - {1'b0, qpos}) : {1'b0, qpos};
    assign tab_val = quarter_tab[tab_idx];

    // Triangle folds twice the phase around one half period.
    logic [PHASE_BITS:0]    twice_ph;
    logic [PHASE_BITS:0]    half_unit;
    logic [PHASE_BITS:0]    fold;
    logic [PHASE_BITS+16:0] fold_sh;
    logic [PHASE_BITS+15:0] ph_sh;
    logic [15:0]            ramp;

    assign twice_ph  = {phase, 1'b0};
    assign half_unit = (PHASE_BITS + 1)'(1) << PHASE_BITS;
    assign fold      = (twice_ph >= half_unit) ? (twice_ph - half_unit) : (half_unit - twice_ph);
    assign fold_sh   = {fold, 16'b0} >> PHASE_BITS;
    assign ph_sh     = {phase, 16'b0} >> PHASE_BITS;
    assign ramp      = ph_sh[15:0];

    logic signed [17:0] val;

    always_comb begin
        val = '0;
        unique case (wave_shape)
            WAVE_SINE: begin
                val = quad[1] ? -$signed({2'b00, tab_val}) : $signed({2'b00, tab_val});
            end
            WAVE_SQUARE: begin
                val = (pos_in_period < (period >> 1)) ? 18'sd32767 : -18'sd32768;
            end
            WAVE_TRIANGLE: begin
                val = $signed({1'b0, fold_sh[16:0]}) - 18'sd32768;
            end
            WAVE_SAW: begin
                val = $signed({2'b00, ramp}) - 18'sd32768;
            end
            WAVE_RSAW: begin
                val = 18'sd32768 - $signed({2'b00, ramp});
            end
            default: begin
                val = '0;
            end
        endcase
    end

    always_comb begin
        if (val > 18'sd32767) begin
            sample = 16'h7FFF;
        end else if (val < -18'sd32768) begin
            sample = 16'h8000;
        end else begin
            sample = val[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* design/multi_waveform_oscillator_top.sv */
// Top level of the multi-waveform oscillator: sequencer, registers, ports.
// Depends on mwo_pkg, mwo_divider and mwo_shaper.
`default_nettype none

// One input word is one sample tick carrying the tone frequency in unsigned
// Q16.16 hertz; one output word is the signed Q1.15 sample of the selected
// wave. All divisions run on a single shared restoring divider that yields
// one quotient bit per cycle, in turn for the period, the position within
// the period and the phase, with sequencing states between them.
// Frequencies below 0.01 Hz skip the divisions and a zero period skips the
// position and phase; both give a zero sample. The input is not ready while a
// sample is being computed; a finished sample waits in the output register,
// and the next word is taken meanwhile. Configuration writes are taken at any
// time, but must be issued only while no sample is in flight.
module multi_waveform_oscillator_top
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [FREQ_W-1:0]      s_tdata,   // [31:0] tone_freq
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [SAMPLE_W-1:0]    m_tdata,   // [15:0] sample_out
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [RATE_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PERIOD,
        S_MOD,
        S_PHASE,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [RATE_W-1:0]       rate_hz_reg;
    logic [SHAPE_W-1:0]      wave_shape_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [DIV_W-1:0]        period_reg;
    logic [DIV_W-1:0]        pos_reg;
    logic [PHASE_BITS-1:0]   phase_reg;
    logic                    zero_reg;
    logic                    m_tvalid_reg;
    logic [SAMPLE_W-1:0]     m_tdata_reg;

    div_cmd_t                div_cmd;
    logic [DIV_W-1:0]        div_rem_init;
    logic [DIV_W-1:0]        div_dividend;
    logic [DIV_W-1:0]        div_divisor;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quo;
    logic [DIV_W-1:0]        div_rem;

    logic                    s_accept;
    logic                    slow_tone;
    logic                    out_free;
    logic                    finish_fire;
    logic [DIV_W-1:0]        pos_plus;
    logic [COUNT_W-1:0]      count_next;
    logic [SAMPLE_W-1:0]     shaped;

    assign s_tready    = (state_reg == S_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign slow_tone   = (s_tdata < MIN_FREQ_RAW);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish_fire = (state_reg == S_FINISH) && out_free;
    assign cfg_ready   = 1'b1;

    // The position is below the period, so the wrap needs a single compare.
    assign pos_plus   = pos_reg + DIV_W'(1);
    assign count_next = (pos_plus == period_reg) ? '0 : pos_plus[COUNT_W-1:0];

    always_comb begin
        div_cmd      = '0;
        div_rem_init = '0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && !slow_tone) begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = DIV_STEP_W'(DIV_W);
                    div_dividend  = {rate_hz_reg, 16'b0};
                    div_divisor   = DIV_W'(s_tdata);
                end
            end
            S_PERIOD: begin
                if (div_done && (div_quo != '0)) begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = DIV_STEP_W'(COUNT_W);
                    div_dividend  = {count_reg, {(DIV_W - COUNT_W){1'b0}}};
                    div_divisor   = div_quo;
                end
            end
            S_MOD: begin
                if (div_done) begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = DIV_STEP_W'(PHASE_BITS);
                    div_rem_init  = div_rem;
                    div_divisor   = period_reg;
                end
            end
            S_PHASE, S_FINISH: begin
                div_cmd = '0;
            end
            default: begin
                div_cmd = '0;
            end
        endcase
    end

    mwo_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (div_cmd),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    mwo_shaper #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_shaper (
        .wave_shape    (wave_shape_reg),
        .phase         (phase_reg),
        .pos_in_period (pos_reg),
        .period        (period_reg),
        .sample        (shaped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rate_hz_reg    <= RATE_RESET;
            wave_shape_reg <= WAVE_SINE;
            count_reg      <= '0;
            zero_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_SAMPLE_RATE) begin
                    rate_hz_reg <= cfg_data;
                end else if (cfg_index == CFG_WAVE_SHAPE) begin
                    wave_shape_reg <= cfg_data[SHAPE_W-1:0];
                end
            end

            if (finish_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        zero_reg  <= slow_tone;
                        state_reg <= slow_tone ? S_FINISH : S_PERIOD;
                    end
                end
                S_PERIOD: begin
                    if (div_done) begin
                        period_reg <= div_quo;
                        if (div_quo == '0) begin
                            count_reg <= '0;
                            zero_reg  <= 1'b1;
                            state_reg <= S_FINISH;
                        end else begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        pos_reg   <= div_rem;
                        state_reg <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    if (div_done) begin
                        phase_reg <= div_quo[PHASE_BITS-1:0];
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_tdata_reg <= zero_reg ? '0 : shaped;
                        if (!zero_reg) begin
                            count_reg <= count_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* design/mwo_checker.sv */
// Port-level checks for the multi-waveform oscillator, bound to the top.
// Depends on multi_waveform_oscillator_top for the bind target.
`default_nettype none

module mwo_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled output word stays valid.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // The block works on one word at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a word");

    // A new sample only appears after the input side has been busy.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("sample appeared without a word in progress");

endmodule

bind multi_waveform_oscillator_top mwo_checker u_mwo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
